>>> hw/rtl/scbt_pkg.sv
// ----------------------------------------------------------------------------
// scbt_pkg: shared types and constants for the serial command block
// Item structs, block geometry, command bytes, result kinds and short
// reply sequences used by the command block.
// ----------------------------------------------------------------------------
package scbt_pkg;

    // Block geometry
    localparam int BLOCK_BYTES = 32;
    localparam int BLOCK_COUNT = 256;
    localparam int IDX_W       = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
    localparam int BLK_W       = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int STORE_DEPTH = BLOCK_BYTES * BLOCK_COUNT;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam logic [15:0] TIMEOUT_RESET = 16'd20000;

    // Command bytes
    localparam logic [7:0] CMD_PING1  = 8'h01;
    localparam logic [7:0] CMD_PING2  = 8'h02;
    localparam logic [7:0] CMD_READ   = 8'h30;
    localparam logic [7:0] CMD_WRITE  = 8'h31;
    localparam logic [7:0] CMD_RDIS   = 8'h45;
    localparam logic [7:0] CMD_REN    = 8'h46;
    localparam logic [7:0] CMD_REBOOT = 8'h49;
    localparam logic [7:0] CMD_RON    = 8'h4A;
    localparam logic [7:0] CMD_ROFF   = 8'h4B;
    localparam logic [7:0] CMD_KEYPRE = 8'h4C;
    localparam logic [7:0] CMD_KEY    = 8'h4D;
    localparam logic [7:0] KEY_LIMIT  = 8'h93;
    localparam logic [7:0] NO_KEY     = 8'd128;
    localparam logic [7:0] TIMER_LOAD = 8'd10;
    localparam logic [7:0] ERASED     = 8'hFF;

    // Result kinds
    localparam logic [2:0] K_TX     = 3'd0;
    localparam logic [2:0] K_KEY    = 3'd1;
    localparam logic [2:0] K_TIMER  = 3'd2;
    localparam logic [2:0] K_RDIS   = 3'd3;
    localparam logic [2:0] K_REN    = 3'd4;
    localparam logic [2:0] K_REBOOT = 3'd5;

    // Short reply sequences
    localparam logic [3:0] R_NONE   = 4'd0;
    localparam logic [3:0] R_ECHO   = 4'd1;
    localparam logic [3:0] R_REBOOT = 4'd2;
    localparam logic [3:0] R_RDIS   = 4'd3;
    localparam logic [3:0] R_REN    = 4'd4;
    localparam logic [3:0] R_RON    = 4'd5;
    localparam logic [3:0] R_ROFF   = 4'd6;
    localparam logic [3:0] R_RKEY   = 4'd7;
    localparam logic [3:0] R_KEY    = 4'd8;
    localparam logic [3:0] R_WACK   = 4'd9;

    typedef struct packed {
        logic       action;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
    } out_item_t;

    function automatic logic [7:0] key_code(input logic [7:0] b);
        key_code = (b < KEY_LIMIT) ? {1'b0, b[6:0]} : NO_KEY;
    endfunction

    function automatic logic [STORE_AW-1:0] store_addr(input logic [BLK_W-1:0] blk,
                                                       input logic [IDX_W-1:0] idx);
        store_addr = STORE_AW'(32'(blk) * 32'(BLOCK_BYTES) + 32'(idx));
    endfunction

    function automatic logic [1:0] resp_len(input logic [3:0] code);
        case (code)
            R_ECHO, R_REBOOT, R_KEY, R_WACK: resp_len = 2'd1;
            R_RDIS, R_REN, R_RKEY:           resp_len = 2'd2;
            R_RON, R_ROFF:                   resp_len = 2'd3;
            default:                         resp_len = 2'd1;
        endcase
    endfunction

    // Item number idx of a short reply; the last flag is filled in by the caller.
    function automatic out_item_t resp_item(input logic [3:0] code, input logic [1:0] idx,
                                            input logic [7:0] b);
        out_item_t it;
        it.kind  = K_TX;
        it.value = b;
        it.last  = 1'b0;
        case (code)
            R_REBOOT: begin
                it.kind  = K_REBOOT;
                it.value = 8'd0;
            end
            R_RDIS, R_REN: begin
                if (idx == 2'd0) begin
                    it.kind  = (code == R_RDIS) ? K_RDIS : K_REN;
                    it.value = 8'd0;
                end
            end
            R_RON, R_ROFF: begin
                if (idx == 2'd0) begin
                    it.kind  = K_KEY;
                    it.value = NO_KEY;
                end else if (idx == 2'd1) begin
                    it.kind  = K_TIMER;
                    it.value = (code == R_RON) ? TIMER_LOAD : 8'd0;
                end
            end
            R_RKEY: begin
                if (idx == 2'd0) begin
                    it.kind  = K_KEY;
                    it.value = key_code(b);
                end else begin
                    it.kind  = K_TIMER;
                    it.value = TIMER_LOAD;
                end
            end
            R_KEY: begin
                it.kind  = K_KEY;
                it.value = key_code(b);
            end
            R_WACK: begin
                it.value = CMD_WRITE;
            end
            default: begin
                it.value = b;
            end
        endcase
        return it;
    endfunction

endpackage

>>> hw/rtl/scbt_ram.sv
// ----------------------------------------------------------------------------
// scbt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/serial_command_block_transfer.sv
// ----------------------------------------------------------------------------
// serial_command_block_transfer: serial command decoder with block store
// Decodes received bytes and poll ticks into reply bytes and events, and
// reads and writes 32-byte blocks of a block store under a sum check.
// ----------------------------------------------------------------------------
// One item at a time: an accepted transfer is decoded in the next cycle, so a
// byte or tick without results then frees the input. Short replies and block
// reads give one result per cycle unless the output stalls; a read sends the
// header, 32 bytes from the block store read port and the sum. A matched block
// write copies 32 bytes via the write buffer read port, then sends the ack.
// Reset clears all control state and the per-block valid bits, so every block
// reads as erased (0xFF) at once; ticks_reg resets to 20000.
module serial_command_block_transfer
    import scbt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [15:0] cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_WAIT    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_RESP    = 3'd2;
    localparam logic [2:0] S_RD_HDR  = 3'd3;
    localparam logic [2:0] S_RD_DATA = 3'd4;
    localparam logic [2:0] S_RD_SUM  = 3'd5;
    localparam logic [2:0] S_COPY    = 3'd6;

    // Command modes
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_KEYPRE = 3'd1;
    localparam logic [2:0] M_KEY    = 3'd2;
    localparam logic [2:0] M_READ   = 3'd3;
    localparam logic [2:0] M_WADDR  = 3'd4;
    localparam logic [2:0] M_WDATA  = 3'd5;
    localparam logic [2:0] M_WSUM   = 3'd6;

    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(BLOCK_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLOCK_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BLOCK_BYTES);

    logic [2:0]             seq_reg, seq_next;
    logic [2:0]             mode_reg, mode_next;
    logic [BLK_W-1:0]       blk_reg, blk_next;
    logic [7:0]             sum_reg, sum_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   remote_reg, remote_next;
    logic [15:0]            left_reg, left_next;
    logic [15:0]            ticks_reg;
    logic [BLOCK_COUNT-1:0] blk_valid_reg, blk_valid_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [3:0]             resp_reg, resp_next;
    logic [1:0]             ridx_reg, ridx_next;
    in_item_t               in_reg;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    logic                   out_free;
    logic [7:0]             store_byte;
    logic [7:0]             add_operand;
    logic [7:0]             sum_add;
    logic                   wbuf_we;
    logic [7:0]             wbuf_rdata;
    logic                   store_we;
    logic [7:0]             store_rdata;
    out_item_t              resp_out;

    assign s_ready   = (seq_reg == S_WAIT);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Unwritten blocks read as erased.
    assign store_byte = blk_valid_reg[blk_reg] ? store_rdata : ERASED;

    // The one shared adder accumulates both write data and read data.
    assign add_operand = (seq_reg == S_RD_DATA) ? store_byte : in_reg.data;
    assign sum_add     = sum_reg + add_operand;

    assign store_we = (seq_reg == S_COPY);
    assign resp_out = resp_item(resp_reg, ridx_reg, in_reg.data);

    // Both RAMs are addressed from the next index, so read data always
    // belongs to the current index.
    scbt_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_wbuf (
        .aclk    (aclk),
        .wr_en   (wbuf_we),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (in_reg.data),
        .rd_addr (idx_next),
        .rd_data (wbuf_rdata)
    );

    scbt_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (store_addr(blk_reg, idx_reg)),
        .wr_data (wbuf_rdata),
        .rd_addr (store_addr(blk_next, idx_next)),
        .rd_data (store_rdata)
    );

    always_comb begin
        seq_next       = seq_reg;
        mode_next      = mode_reg;
        blk_next       = blk_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;
        remote_next    = remote_reg;
        left_next      = left_reg;
        blk_valid_next = blk_valid_reg;
        idx_next       = idx_reg;
        resp_next      = resp_reg;
        ridx_next      = ridx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        wbuf_we        = 1'b0;

        case (seq_reg)
            S_WAIT: begin
                if (s_valid) begin
                    seq_next = S_EXEC;
                end
            end

            S_EXEC: begin
                seq_next  = S_WAIT;
                resp_next = R_NONE;
                ridx_next = 2'd0;
                if (in_reg.action) begin
                    if (mode_reg != M_IDLE) begin
                        if (left_reg == 16'd0) begin
                            mode_next = M_IDLE;
                        end else begin
                            left_next = left_reg - 16'd1;
                        end
                    end
                end else begin
                    case (mode_reg)
                        M_KEYPRE: begin
                            mode_next = (in_reg.data == CMD_KEY) ? M_KEY : M_IDLE;
                        end
                        M_KEY: begin
                            mode_next = M_IDLE;
                            resp_next = R_KEY;
                        end
                        M_READ: begin
                            mode_next = M_IDLE;
                            blk_next  = BLK_W'(32'(in_reg.data) % BLOCK_COUNT);
                            sum_next  = 8'd0;
                            seq_next  = S_RD_HDR;
                        end
                        M_WADDR: begin
                            mode_next = M_WDATA;
                            blk_next  = BLK_W'(32'(in_reg.data) % BLOCK_COUNT);
                            sum_next  = 8'd0;
                            fill_next = '0;
                        end
                        M_WDATA: begin
                            wbuf_we   = (fill_reg < FILL_FULL);
                            fill_next = fill_reg + FILL_W'(1);
                            sum_next  = sum_add;
                            if (fill_reg >= FILL_LAST) begin
                                mode_next = M_WSUM;
                            end
                        end
                        M_WSUM: begin
                            mode_next = M_IDLE;
                            if (in_reg.data == sum_reg) begin
                                seq_next = S_COPY;
                                idx_next = '0;
                            end
                        end
                        default: begin
                            mode_next = M_IDLE;
                            if (in_reg.data[7]) begin
                                if (remote_reg) begin
                                    resp_next = R_RKEY;
                                end
                            end else begin
                                case (in_reg.data)
                                    CMD_REBOOT: resp_next = R_REBOOT;
                                    CMD_KEYPRE: mode_next = M_KEYPRE;
                                    CMD_READ:   mode_next = M_READ;
                                    CMD_WRITE:  mode_next = M_WADDR;
                                    CMD_PING1, CMD_PING2: resp_next = R_ECHO;
                                    CMD_RDIS:   resp_next = R_RDIS;
                                    CMD_REN:    resp_next = R_REN;
                                    CMD_RON: begin
                                        resp_next   = R_RON;
                                        remote_next = 1'b1;
                                    end
                                    CMD_ROFF: begin
                                        resp_next   = R_ROFF;
                                        remote_next = 1'b0;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    endcase
                    if (resp_next != R_NONE) begin
                        seq_next = S_RESP;
                    end
                    if (mode_next != M_IDLE) begin
                        left_next = ticks_reg - 16'd1;
                    end
                end
            end

            S_RESP: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next      = resp_out;
                    m_data_next.last = (ridx_reg == (resp_len(resp_reg) - 2'd1));
                    if (m_data_next.last) begin
                        seq_next = S_WAIT;
                    end else begin
                        ridx_next = ridx_reg + 2'd1;
                    end
                end
            end

            S_RD_HDR: begin
                idx_next = '0;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: K_TX, value: CMD_READ, last: 1'b0};
                    seq_next     = S_RD_DATA;
                end
            end

            S_RD_DATA: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: K_TX, value: store_byte, last: 1'b0};
                    sum_next     = sum_add;
                    if (idx_reg == IDX_LAST) begin
                        seq_next = S_RD_SUM;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            S_RD_SUM: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: K_TX, value: sum_reg, last: 1'b1};
                    seq_next     = S_WAIT;
                end
            end

            S_COPY: begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_LAST) begin
                    blk_valid_next[blk_reg] = 1'b1;
                    resp_next = R_WACK;
                    ridx_next = 2'd0;
                    seq_next  = S_RESP;
                end
            end

            default: begin
                seq_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= S_WAIT;
            mode_reg      <= M_IDLE;
            blk_reg       <= '0;
            sum_reg       <= 8'd0;
            fill_reg      <= '0;
            remote_reg    <= 1'b0;
            left_reg      <= 16'd0;
            ticks_reg     <= TIMEOUT_RESET;
            blk_valid_reg <= '0;
            idx_reg       <= '0;
            resp_reg      <= R_NONE;
            ridx_reg      <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            seq_reg       <= seq_next;
            mode_reg      <= mode_next;
            blk_reg       <= blk_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            remote_reg    <= remote_next;
            left_reg      <= left_next;
            blk_valid_reg <= blk_valid_next;
            idx_reg       <= idx_next;
            resp_reg      <= resp_next;
            ridx_reg      <= ridx_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                ticks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    // An accepted transfer is always decoded in the following cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> seq_reg == S_EXEC)
        else $error("accepted transfer not decoded");

    // Block reads and copies only run once the command has returned to idle.
    a_read_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg == S_RD_DATA || seq_reg == S_COPY) |-> mode_reg == M_IDLE)
        else $error("block sequence running outside idle mode");

    // The sum byte is only awaited with a full write buffer.
    a_wsum_full: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == M_WSUM |-> fill_reg == FILL_FULL)
        else $error("write sum awaited with partial buffer");

endmodule
